// File: hw/rtl/route_cache_with_aging_top_assert.svh
// Assertion macros for the route cache checker.
// No dependencies; included by the checker file.
`ifndef ROUTE_CACHE_WITH_AGING_TOP_ASSERT_SVH
`define ROUTE_CACHE_WITH_AGING_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rca_pkg.sv
// Shared types and constants for the route cache.
// No dependencies; used by the top, front, queue and back modules.
package rca_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned QUEUE_DEPTH_DEF   = 2;

  // Operation codes of an incoming transaction
  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_ERASE  = 2'd2,
    KIND_AGE    = 2'd3
  } kind_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } back_state_e;

  // Classified command passed from front to back
  typedef struct packed {
    kind_e       kind;
    logic [31:0] dest_addr;
    logic [31:0] next_hop;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic        hit;
    logic [31:0] next_hop;
    logic        dropped;
  } res_t;

  // Queue status seen by producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hw/rtl/route_cache_with_aging_top.sv
// Route cache with aging: exact-match destination -> next hop table.
// Lookup, update and erase scan the key memory one entry per cycle (one read port),
// ending on a hit or after the last entry. An age sweep needs no scan. A command passes
// the front holding register, the queue and the back end before its result is registered.
// The back end takes a new command only after the last result has left it; output stalls hold it.
// Reset (rst_ni low, asynchronous) clears all valid and used marks at once.
module route_cache_with_aging_top #(
  parameter int unsigned TABLE_ENTRIES = rca_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned QUEUE_DEPTH   = rca_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] dest_addr_i,
  input  logic [31:0] next_hop_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [31:0] next_hop_out_o,
  output logic        dropped_o
);

  rca_pkg::cmd_t    front_cmd, queue_cmd;
  rca_pkg::q_stat_t q_stat;
  logic             push, pop;

  // Accept and classify
  rca_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .dest_addr_i   (dest_addr_i),
    .next_hop_in_i (next_hop_in_i),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  // Decoupling queue
  rca_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (front_cmd),
    .pop_i  (pop),
    .cmd_o  (queue_cmd),
    .stat_o (q_stat)
  );

  // Table execution and result register
  rca_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .cmd_i          (queue_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .next_hop_out_o (next_hop_out_o),
    .dropped_o      (dropped_o)
  );

endmodule

// File: hw/rtl/rca_front.sv
// Front end: accepts input transactions, decodes the kind, feeds the queue.
// Depends on rca_pkg.
module rca_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      kind_i,
  input  logic [31:0]     dest_addr_i,
  input  logic [31:0]     next_hop_in_i,
  input  rca_pkg::q_stat_t q_stat_i,
  output logic            push_o,
  output rca_pkg::cmd_t   cmd_o
);

  logic          vld_q, vld_d;
  rca_pkg::cmd_t cmd_q, cmd_d;
  logic          accept;

  // Stall only while the holding register is full and cannot drain
  assign in_stall_o = vld_q & q_stat_i.full;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = vld_q & ~q_stat_i.full;
  assign cmd_o      = cmd_q;

  // Classify: decode kind, next hop only matters for an update
  always_comb begin
    cmd_d = cmd_q;
    vld_d = vld_q & ~push_o;
    if (accept) begin
      vld_d          = 1'b1;
      cmd_d.kind     = rca_pkg::kind_e'(kind_i);
      cmd_d.dest_addr = dest_addr_i;
      if (rca_pkg::kind_e'(kind_i) == rca_pkg::KIND_UPDATE) begin
        cmd_d.next_hop = next_hop_in_i;
      end else begin
        cmd_d.next_hop = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// File: hw/rtl/rca_queue.sv
// Short command queue between the front and back ends.
// Depends on rca_pkg.
module rca_queue #(
  parameter int unsigned DEPTH = rca_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rca_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output rca_pkg::cmd_t    cmd_o,
  output rca_pkg::q_stat_t stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  rca_pkg::cmd_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign cmd_o        = mem_q[rd_ptr_q];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: hw/rtl/rca_back.sv
// Back end: scans the key/next-hop memories, applies the command, drives results.
// Depends on rca_pkg.
module rca_back #(
  parameter int unsigned TABLE_ENTRIES = rca_pkg::TABLE_ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rca_pkg::q_stat_t q_stat_i,
  input  rca_pkg::cmd_t    cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             hit_o,
  output logic [31:0]      next_hop_out_o,
  output logic             dropped_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Key and next-hop memories: one write, one registered read per cycle
  logic [31:0] key_mem [TABLE_ENTRIES];
  logic [31:0] hop_mem [TABLE_ENTRIES];
  logic [31:0] key_rd_q, hop_rd_q;

  rca_pkg::back_state_e   state_q, state_d;
  rca_pkg::cmd_t          cmd_q, cmd_d;
  rca_pkg::res_t          res_q, res_d, out_q, out_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d, used_q, used_d;
  logic [IDX_W-1:0]       idx_q, idx_d, chk_idx_q, chk_idx_d, free_idx_q, free_idx_d;
  logic                   issue_done_q, issue_done_d;
  logic                   chk_vld_q, chk_vld_d;
  logic                   free_found_q, free_found_d;
  logic                   out_vld_q, out_vld_d;
  logic                   rd_en, key_we, hop_we;
  logic [IDX_W-1:0]       wr_addr;
  logic                   hit_now, free_now, last_chk, out_free;

  // Check stage: registered read data against the command key
  assign hit_now  = chk_vld_q & valid_q[chk_idx_q] & (key_rd_q == cmd_q.dest_addr);
  assign free_now = chk_vld_q & ~valid_q[chk_idx_q];
  assign last_chk = chk_vld_q & (chk_idx_q == LAST_IDX);
  assign out_free = ~out_vld_q | ~out_stall_i;

  assign out_valid_o    = out_vld_q;
  assign hit_o          = out_q.hit;
  assign next_hop_out_o = out_q.next_hop;
  assign dropped_o      = out_q.dropped;

  // Sequencer: next state, table updates, result staging
  always_comb begin
    logic [IDX_W-1:0] slot;
    slot         = free_found_q ? free_idx_q : chk_idx_q;
    state_d      = state_q;
    cmd_d        = cmd_q;
    res_d        = res_q;
    out_d        = out_q;
    out_vld_d    = out_vld_q & out_stall_i;
    valid_d      = valid_q;
    used_d       = used_q;
    idx_d        = idx_q;
    issue_done_d = issue_done_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    pop_o        = 1'b0;
    rd_en        = 1'b0;
    key_we       = 1'b0;
    hop_we       = 1'b0;
    wr_addr      = chk_idx_q;

    case (state_q)
      rca_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          res_d = '0;
          if (cmd_i.kind == rca_pkg::KIND_AGE) begin
            // Age sweep: drop unused entries, clear all used marks at once
            valid_d = valid_q & used_q;
            used_d  = '0;
            state_d = rca_pkg::BK_DONE;
          end else begin
            idx_d        = '0;
            issue_done_d = 1'b0;
            free_found_d = 1'b0;
            state_d      = rca_pkg::BK_SCAN;
          end
        end
      end

      rca_pkg::BK_SCAN: begin
        // Issue one read per cycle
        if (!issue_done_q) begin
          rd_en     = 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = idx_q;
          if (idx_q == LAST_IDX) begin
            issue_done_d = 1'b1;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
        // Remember the lowest free slot for an insert
        if (free_now && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = chk_idx_q;
        end
        if (hit_now) begin
          chk_vld_d = 1'b0;
          res_d.hit = 1'b1;
          state_d   = rca_pkg::BK_DONE;
          case (cmd_q.kind)
            rca_pkg::KIND_LOOKUP: begin
              res_d.next_hop    = hop_rd_q;
              used_d[chk_idx_q] = 1'b1;
            end
            rca_pkg::KIND_UPDATE: begin
              hop_we            = 1'b1;
              used_d[chk_idx_q] = 1'b1;
            end
            rca_pkg::KIND_ERASE: begin
              valid_d[chk_idx_q] = 1'b0;
              used_d[chk_idx_q]  = 1'b0;
            end
            default: ;
          endcase
        end else if (last_chk) begin
          state_d = rca_pkg::BK_DONE;
          // Miss: an update inserts into the lowest free slot or is dropped
          if (cmd_q.kind == rca_pkg::KIND_UPDATE) begin
            if (free_found_q || free_now) begin
              key_we        = 1'b1;
              hop_we        = 1'b1;
              wr_addr       = slot;
              valid_d[slot] = 1'b1;
              used_d[slot]  = 1'b1;
            end else begin
              res_d.dropped = 1'b1;
            end
          end
        end
      end

      rca_pkg::BK_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = res_q;
          state_d   = rca_pkg::BK_IDLE;
        end
      end

      default: begin
        state_d = rca_pkg::BK_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rca_pkg::BK_IDLE;
      valid_q      <= '0;
      used_q       <= '0;
      idx_q        <= '0;
      issue_done_q <= 1'b0;
      chk_vld_q    <= 1'b0;
      free_found_q <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      used_q       <= used_d;
      idx_q        <= idx_d;
      issue_done_q <= issue_done_d;
      chk_vld_q    <= chk_vld_d;
      free_found_q <= free_found_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    res_q      <= res_d;
    out_q      <= out_d;
    chk_idx_q  <= chk_idx_d;
    free_idx_q <= free_idx_d;
  end

  // Key memory
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= cmd_q.dest_addr;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[idx_q];
    end
  end

  // Next-hop memory
  always_ff @(posedge clk_i) begin
    if (hop_we) begin
      hop_mem[wr_addr] <= cmd_q.next_hop;
    end
    if (rd_en) begin
      hop_rd_q <= hop_mem[idx_q];
    end
  end

endmodule

// File: hw/rtl/rca_checker.sv
// Port-level checker for the route cache, bound to the top level.
// Depends on route_cache_with_aging_top_assert.svh.
`include "route_cache_with_aging_top_assert.svh"

module rca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        hit_o,
  input logic [31:0] next_hop_out_o,
  input logic        dropped_o
);

  // A stalled result stays offered
  `RCA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // A stalled result keeps its payload
  `RCA_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(hit_o) && $stable(next_hop_out_o) && $stable(dropped_o), "stalled result changed")

  // A dropped insert never reports a hit
  `RCA_ASSERT_NOW(a_drop_no_hit, clk_i, rst_ni, out_valid_o && dropped_o, !hit_o, "dropped and hit together")

  // A nonzero next hop only comes from a hit
  `RCA_ASSERT_NOW(a_hop_needs_hit, clk_i, rst_ni, out_valid_o && (next_hop_out_o != 32'd0), hit_o && !dropped_o, "next hop without hit")

endmodule

bind route_cache_with_aging_top rca_checker u_rca_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .hit_o          (hit_o),
  .next_hop_out_o (next_hop_out_o),
  .dropped_o      (dropped_o)
);
